/* src/psle_pkg.sv */
// ----------------------------------------------------------------------------
// psle_pkg: shared types and constants for the positional sorted list engine
// Request and status codes, default sizes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package psle_pkg;

  // Default sizing of the list.
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Request kinds; code 7 is unused and answers ok with no change.
  typedef enum logic [2:0] {
    OP_INSERT_AT     = 3'd0,
    OP_INSERT_SORTED = 3'd1,
    OP_ERASE_AT      = 3'd2,
    OP_REMOVE_ALL    = 3'd3,
    OP_READ_AT       = 3'd4,
    OP_WRITE_AT      = 3'd5,
    OP_FIND          = 3'd6
  } op_t;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic fwd;
    logic bwd;
    logic put;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic err;
    logic fwd_done;
    logic bwd_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* src/positional_sorted_list_engine.sv */
// ----------------------------------------------------------------------------
// positional_sorted_list_engine: ordered list with positional and sorted ops
// Top level joining the request sequencer and the list datapath.
// ----------------------------------------------------------------------------
// One request is worked at a time. Each passes through accept, decode and
// response, and between them through a forward scan, a backward shift or a
// final write as its kind needs; the entry memory has one write port and one
// registered read port and moves one entry per cycle. Insert at a position
// shifts the tail up from the end, erase shifts it down, remove all scans the
// whole list and find scans up to the first match. A sorted insert scans
// forward to its slot and then shifts the tail. A new request word is taken
// once the previous response is in the output register.
`default_nettype none

module positional_sorted_list_engine #(
  parameter int CAPACITY   = psle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = psle_pkg::DATA_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [6:0]  in_position,
  input  wire logic [31:0] in_item_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [6:0]       out_index_or_count,
  output logic [31:0]      out_read_value,
  output logic [6:0]       out_entry_count
);
  import psle_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // Request sequencer.
  psle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // List storage and datapath.
  psle_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_req_type        (in_req_type),
    .in_position        (in_position),
    .in_item_value      (in_item_value),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_index_or_count (out_index_or_count),
    .out_read_value     (out_read_value),
    .out_entry_count    (out_entry_count)
  );

endmodule

`default_nettype wire

/* src/psle_ctrl.sv */
// ----------------------------------------------------------------------------
// psle_ctrl: request sequencer
// One-hot state machine that steps each request through decode, forward scan,
// backward shift, final write and response.
// ----------------------------------------------------------------------------
`default_nettype none

module psle_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  psle_pkg::stat_t    st,
  output psle_pkg::cmd_t     cmd
);
  import psle_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_FWD  = 6'b000100,
    S_BWD  = 6'b001000,
    S_PUT  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // A new word is taken only between requests.
  assign in_stall = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        if (st.err) begin
          state_nxt = S_FIN;
        end else begin
          case (st.op)
            OP_INSERT_AT: state_nxt = S_BWD;
            OP_WRITE_AT:  state_nxt = S_PUT;
            OP_INSERT_SORTED, OP_ERASE_AT, OP_REMOVE_ALL, OP_READ_AT, OP_FIND:
              state_nxt = S_FWD;
            default:      state_nxt = S_FIN;
          endcase
        end
      end
      S_FWD: begin
        cmd.fwd = 1'b1;
        if (st.fwd_done) begin
          state_nxt = (st.op == OP_INSERT_SORTED) ? S_BWD : S_FIN;
        end
      end
      S_BWD: begin
        cmd.bwd = 1'b1;
        if (st.bwd_done) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/psle_dp.sv */
// ----------------------------------------------------------------------------
// psle_dp: list storage and datapath
// Entry memory with a registered read port, scan and shift pointers, result
// registers and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module psle_dp #(
  parameter int CAPACITY   = psle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = psle_pkg::DATA_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [2:0]    in_req_type,
  input  wire logic [6:0]    in_position,
  input  wire logic [31:0]   in_item_value,
  input  psle_pkg::cmd_t     cmd,
  output psle_pkg::stat_t    st,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_status,
  output logic [6:0]         out_index_or_count,
  output logic [31:0]        out_read_value,
  output logic [6:0]         out_entry_count
);
  import psle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (CW > 7) ? CW : 7;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  op_t                   op_r;
  logic [6:0]            pos_in_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         pos_r;
  logic [CW-1:0]         rd_ptr_r;
  logic [CW-1:0]         lim_r;
  logic [CW-1:0]         w_r;
  logic [CW-1:0]         hits_r;
  logic                  pv_r;
  logic [AW-1:0]         pa_r;
  logic [DATA_WIDTH-1:0] rdata_r;
  status_t               res_status_r;
  logic [CW-1:0]         res_idx_r;
  logic [DATA_WIDTH-1:0] res_rd_r;
  logic                  out_vld_r;

  logic [63:0]           in_ext;
  logic [63:0]           rd_ext;
  logic [XW-1:0]         pos_x;
  logic [XW-1:0]         cnt_x;
  logic [XW-1:0]         idx_x;
  logic                  full;
  logic                  dec_err;
  status_t               dec_status;
  logic                  can_fwd;
  logic                  can_bwd;
  logic                  hit;
  logic                  fwd_issue;
  logic                  bwd_issue;
  logic                  fwd_done;
  logic                  bwd_done;
  logic [AW-1:0]         rd_addr;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [DATA_WIDTH-1:0] wd;

  // Width conversions between the fixed port fields and the sized list.
  assign in_ext = {32'd0, in_item_value};
  assign rd_ext = 64'(res_rd_r);
  assign pos_x  = XW'(pos_in_r);
  assign cnt_x  = XW'(count_r);
  assign idx_x  = XW'(res_idx_r);

  // Request check: position range first, then fullness.
  assign full = (count_r == CW'(CAPACITY));
  always_comb begin
    dec_status = ST_OK;
    case (op_r)
      OP_INSERT_AT: begin
        if (pos_x > cnt_x) begin
          dec_status = ST_BADPOS;
        end else if (full) begin
          dec_status = ST_FULL;
        end
      end
      OP_INSERT_SORTED: begin
        if (full) begin
          dec_status = ST_FULL;
        end
      end
      OP_ERASE_AT, OP_READ_AT, OP_WRITE_AT: begin
        if (pos_x >= cnt_x) begin
          dec_status = ST_BADPOS;
        end
      end
      default: dec_status = ST_OK;
    endcase
  end
  assign dec_err = (dec_status != ST_OK);

  // Scan and shift pipeline control.
  assign hit = pv_r && (((op_r == OP_INSERT_SORTED) && (val_r <= rdata_r)) ||
                        ((op_r == OP_FIND) && (val_r == rdata_r)));
  assign can_fwd   = (rd_ptr_r < lim_r);
  assign can_bwd   = (rd_ptr_r > pos_r);
  assign fwd_issue = cmd.fwd && can_fwd && !hit;
  assign bwd_issue = cmd.bwd && can_bwd;
  assign fwd_done  = hit || (!can_fwd && !pv_r);
  assign bwd_done  = !can_bwd && !pv_r;
  assign rd_addr   = cmd.bwd ? AW'(rd_ptr_r - 1'b1) : rd_ptr_r[AW-1:0];

  // Memory write select: compaction, erase shift, insert shift, final write.
  always_comb begin
    we = 1'b0;
    wa = pa_r;
    wd = rdata_r;
    if (cmd.fwd && pv_r && (op_r == OP_REMOVE_ALL) && (rdata_r != val_r)) begin
      we = 1'b1;
      wa = w_r[AW-1:0];
    end else if (cmd.fwd && pv_r && (op_r == OP_ERASE_AT)) begin
      we = 1'b1;
      wa = AW'(pa_r - 1'b1);
    end else if (cmd.bwd && pv_r) begin
      we = 1'b1;
      wa = AW'(pa_r + 1'b1);
    end else if (cmd.put) begin
      we = 1'b1;
      wa = pos_r[AW-1:0];
      wd = val_r;
    end
  end

  // Entry memory with one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      pv_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      pv_r <= fwd_issue || bwd_issue;
      if (cmd.fwd && fwd_done && (op_r == OP_REMOVE_ALL)) begin
        count_r <= w_r;
      end else if (cmd.fwd && fwd_done && (op_r == OP_ERASE_AT)) begin
        count_r <= count_r - 1'b1;
      end else if (cmd.put && (op_r != OP_WRITE_AT)) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.fin) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Request, pointer and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op_t'(in_req_type);
      pos_in_r <= in_position;
      val_r    <= in_ext[DATA_WIDTH-1:0];
    end
    if (cmd.decode) begin
      res_status_r <= (op_r == OP_FIND && !dec_err) ? ST_NOTFOUND : dec_status;
      res_idx_r    <= '0;
      res_rd_r     <= '0;
      pos_r        <= pos_x[CW-1:0];
      w_r          <= '0;
      hits_r       <= '0;
      case (op_r)
        OP_INSERT_AT: rd_ptr_r <= count_r;
        OP_ERASE_AT:  rd_ptr_r <= CW'(pos_x + 1'b1);
        OP_READ_AT:   rd_ptr_r <= pos_x[CW-1:0];
        default:      rd_ptr_r <= '0;
      endcase
      lim_r <= (op_r == OP_READ_AT) ? CW'(pos_x + 1'b1) : count_r;
    end
    // Forward scan: issue reads upward, act on the word read last cycle.
    if (cmd.fwd) begin
      if (fwd_issue) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
        pa_r     <= rd_addr;
      end
      if (pv_r) begin
        case (op_r)
          OP_REMOVE_ALL: begin
            if (rdata_r == val_r) begin
              hits_r <= hits_r + 1'b1;
            end else begin
              w_r <= w_r + 1'b1;
            end
          end
          OP_READ_AT: begin
            res_rd_r  <= rdata_r;
            res_idx_r <= CW'(pa_r);
          end
          OP_FIND: begin
            if (hit) begin
              res_status_r <= ST_OK;
              res_idx_r    <= CW'(pa_r);
            end
          end
          OP_INSERT_SORTED: begin
            if (hit) begin
              pos_r <= CW'(pa_r);
            end
          end
          default: ;
        endcase
      end
      if (fwd_done) begin
        case (op_r)
          OP_INSERT_SORTED: begin
            rd_ptr_r <= count_r;
            if (!hit) begin
              pos_r <= count_r;
            end
          end
          OP_REMOVE_ALL: res_idx_r <= hits_r;
          OP_ERASE_AT:   res_idx_r <= pos_r;
          default: ;
        endcase
      end
    end
    // Backward shift: issue reads downward, each word moves up one slot.
    if (bwd_issue) begin
      rd_ptr_r <= rd_ptr_r - 1'b1;
      pa_r     <= rd_addr;
    end
    if (cmd.put) begin
      res_idx_r <= pos_r;
    end
    // Output word register.
    if (cmd.fin) begin
      out_status         <= res_status_r;
      out_index_or_count <= idx_x[6:0];
      out_read_value     <= rd_ext[31:0];
      out_entry_count    <= cnt_x[6:0];
    end
  end

  assign out_valid   = out_vld_r;
  assign st.op       = op_r;
  assign st.err      = dec_err;
  assign st.fwd_done = fwd_done;
  assign st.bwd_done = bwd_done;
  assign st.out_free = !out_vld_r || !out_stall;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.bwd && pv_r) |-> (CW'(pa_r) < count_r))
    else $error("insert shift writes beyond the list end");

  a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fwd && (op_r == OP_REMOVE_ALL)) |-> (w_r <= rd_ptr_r))
    else $error("compaction write pointer ran ahead of the read pointer");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_vld_r || !out_stall))
    else $error("output word overwritten before it was taken");
`endif

endmodule

`default_nettype wire
